// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define SBFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SBFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sbfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sbfd_pkg
// Types and constants of the serial-bus frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int CHANNELS    = 16;
  localparam int CODE_W      = 11;
  localparam int OFS_W       = 12;
  localparam int PAYLOAD_W   = CHANNELS * CODE_W;
  localparam int WPOS_W      = 5;
  localparam int IDX_W       = 4;
  localparam int REG_IDX_W   = 3;

  localparam logic [7:0] HEADER_CODE = 8'h0F;
  localparam logic [7:0] FLAG_CODE   = 8'h00;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_IDLE = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_LOSS_LIMIT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STICK_CENTER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KNOB_BASE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SWITCH_UP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SWITCH_MID   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SWITCH_DOWN  = 3'd5;

  localparam logic [7:0]        RST_LOSS_LIMIT   = 8'd50;
  localparam logic [CODE_W-1:0] RST_STICK_CENTER = 11'd992;
  localparam logic [CODE_W-1:0] RST_KNOB_BASE    = 11'd192;
  localparam logic [CODE_W-1:0] RST_SWITCH_UP    = 11'd192;
  localparam logic [CODE_W-1:0] RST_SWITCH_MID   = 11'd992;
  localparam logic [CODE_W-1:0] RST_SWITCH_DOWN  = 11'd1792;

  localparam logic [7:0] LOSS_MAX = 8'hFF;

  localparam logic [1:0] SW_UP    = 2'd0;
  localparam logic [1:0] SW_MID   = 2'd1;
  localparam logic [1:0] SW_DOWN  = 2'd2;
  localparam logic [1:0] SW_NONE  = 2'd3;

  localparam logic [IDX_W-1:0] CH_SW3_A = 4'd4;
  localparam logic [IDX_W-1:0] CH_SW3_B = 4'd7;
  localparam logic [IDX_W-1:0] CH_SW2_A = 4'd5;
  localparam logic [IDX_W-1:0] CH_SW2_B = 4'd6;
  localparam logic [IDX_W-1:0] CH_LAST  = 4'd15;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_STATUS
  } seq_state_t;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic                    frame_valid;
    logic                    connected;
    logic [IDX_W-1:0]        channel_index;
    logic [CODE_W-1:0]       channel_value;
    logic signed [OFS_W-1:0] center_offset;
    logic signed [OFS_W-1:0] knob_offset;
    logic [1:0]              switch_position;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic                 hdr_ok;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic              frame_valid;
    logic              connected;
    logic              last;
    logic [IDX_W-1:0]  index;
    logic [CODE_W-1:0] value;
  } beat_t;

endpackage

// ----- src/sbfd_store.sv -----
// ----------------------------------------------------------------------------
// sbfd_store
// Byte capture register file with write pointer and frame check.
// ----------------------------------------------------------------------------
module sbfd_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_we,
  input  logic [7:0]        byte_in,
  input  logic              frame_end,
  output sbfd_pkg::frame_t  frame
);

  logic [7:0]                   bytes_r   [sbfd_pkg::FRAME_BYTES];
  logic [7:0]                   bytes_nxt [sbfd_pkg::FRAME_BYTES];
  logic [sbfd_pkg::WPOS_W-1:0]  wpos_r;
  logic [sbfd_pkg::WPOS_W-1:0]  wpos_nxt;

  always_comb begin
    bytes_nxt = bytes_r;
    wpos_nxt  = wpos_r;
    for (int i = 0; i < sbfd_pkg::FRAME_BYTES; i++) begin
      if (byte_we && wpos_r == sbfd_pkg::WPOS_W'(i)) begin
        bytes_nxt[i] = byte_in;
      end
    end
    if (frame_end) begin
      wpos_nxt = '0;
    end else if (byte_we && wpos_r < sbfd_pkg::WPOS_W'(sbfd_pkg::FRAME_BYTES)) begin
      wpos_nxt = wpos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbfd_pkg::FRAME_BYTES; i++) begin
        bytes_r[i] <= '0;
      end
      wpos_r <= '0;
    end else begin
      bytes_r <= bytes_nxt;
      wpos_r  <= wpos_nxt;
    end
  end

  always_comb begin
    frame.hdr_ok = (bytes_r[0] == sbfd_pkg::HEADER_CODE) &&
                   (bytes_r[sbfd_pkg::FRAME_BYTES-1] == sbfd_pkg::FLAG_CODE);
    frame.payload = '0;
    for (int i = 1; i < sbfd_pkg::FRAME_BYTES - 1; i++) begin
      frame.payload[8*(i-1) +: 8] = bytes_r[i];
    end
  end

endmodule

// ----- src/sbfd_seq.sv -----
// ----------------------------------------------------------------------------
// sbfd_seq
// Frame sequencer: link status and a shared shifter that peels one channel
// per beat off the frame payload.
// ----------------------------------------------------------------------------
module sbfd_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_end,
  input  sbfd_pkg::frame_t  frame,
  input  logic [7:0]        loss_limit,
  input  logic              beat_ready,
  output logic              busy,
  output logic              beat_valid,
  output sbfd_pkg::beat_t   beat
);

  sbfd_pkg::seq_state_t              state_r;
  sbfd_pkg::seq_state_t              state_nxt;
  logic [sbfd_pkg::PAYLOAD_W-1:0]    shift_r;
  logic [sbfd_pkg::PAYLOAD_W-1:0]    shift_nxt;
  logic [sbfd_pkg::IDX_W-1:0]        idx_r;
  logic [sbfd_pkg::IDX_W-1:0]        idx_nxt;
  logic [7:0]                        loss_r;
  logic [7:0]                        loss_nxt;
  logic                              link_r;
  logic                              link_nxt;
  logic [7:0]                        loss_inc;

  assign loss_inc = (loss_r == sbfd_pkg::LOSS_MAX) ? loss_r : loss_r + 8'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbfd_pkg::S_IDLE: begin
        if (frame_end) begin
          state_nxt = frame.hdr_ok ? sbfd_pkg::S_EMIT : sbfd_pkg::S_STATUS;
        end
      end
      sbfd_pkg::S_EMIT: begin
        if (beat_ready && idx_r == sbfd_pkg::CH_LAST) begin
          state_nxt = sbfd_pkg::S_IDLE;
        end
      end
      sbfd_pkg::S_STATUS: begin
        if (beat_ready) begin
          state_nxt = sbfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sbfd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    shift_nxt  = shift_r;
    idx_nxt    = idx_r;
    loss_nxt   = loss_r;
    link_nxt   = link_r;
    busy       = 1'b1;
    beat_valid = 1'b0;
    case (state_r)
      sbfd_pkg::S_IDLE: begin
        busy = 1'b0;
        if (frame_end) begin
          shift_nxt = frame.payload;
          idx_nxt   = '0;
          if (frame.hdr_ok) begin
            loss_nxt = '0;
            link_nxt = 1'b1;
          end else begin
            loss_nxt = loss_inc;
            link_nxt = (loss_inc >= loss_limit) ? 1'b0 : link_r;
          end
        end
      end
      sbfd_pkg::S_EMIT: begin
        beat_valid = 1'b1;
        if (beat_ready) begin
          shift_nxt = shift_r >> sbfd_pkg::CODE_W;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      sbfd_pkg::S_STATUS: begin
        beat_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    beat.frame_valid = (state_r == sbfd_pkg::S_EMIT);
    beat.connected   = link_r;
    beat.last        = (state_r == sbfd_pkg::S_STATUS) || (idx_r == sbfd_pkg::CH_LAST);
    beat.index       = idx_r;
    beat.value       = shift_r[sbfd_pkg::CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbfd_pkg::S_IDLE;
      idx_r   <= '0;
      loss_r  <= '0;
      link_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      loss_r  <= loss_nxt;
      link_r  <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

endmodule

// ----- src/sbfd_post.sv -----
// ----------------------------------------------------------------------------
// sbfd_post
// Offset and switch decode of one channel beat into the output register.
// ----------------------------------------------------------------------------
module sbfd_post (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         beat_valid,
  input  sbfd_pkg::beat_t              beat,
  input  logic [sbfd_pkg::CODE_W-1:0]  stick_center,
  input  logic [sbfd_pkg::CODE_W-1:0]  knob_base,
  input  logic [sbfd_pkg::CODE_W-1:0]  switch_up_code,
  input  logic [sbfd_pkg::CODE_W-1:0]  switch_mid_code,
  input  logic [sbfd_pkg::CODE_W-1:0]  switch_down_code,
  input  logic                         out_ready,
  output logic                         beat_ready,
  output logic                         out_valid,
  output sbfd_pkg::out_t               out_data
);

  logic            out_valid_r;
  logic            out_valid_nxt;
  sbfd_pkg::out_t  out_data_r;
  sbfd_pkg::out_t  out_data_nxt;
  sbfd_pkg::out_t  res;
  logic [1:0]      sw_pos;
  logic            three_pos;
  logic            two_pos;

  assign three_pos = (beat.index == sbfd_pkg::CH_SW3_A) || (beat.index == sbfd_pkg::CH_SW3_B);
  assign two_pos   = (beat.index == sbfd_pkg::CH_SW2_A) || (beat.index == sbfd_pkg::CH_SW2_B);

  always_comb begin
    sw_pos = sbfd_pkg::SW_NONE;
    if (three_pos) begin
      if (beat.value == switch_up_code) begin
        sw_pos = sbfd_pkg::SW_UP;
      end else if (beat.value == switch_mid_code) begin
        sw_pos = sbfd_pkg::SW_MID;
      end else if (beat.value == switch_down_code) begin
        sw_pos = sbfd_pkg::SW_DOWN;
      end
    end else if (two_pos) begin
      if (beat.value == switch_up_code) begin
        sw_pos = sbfd_pkg::SW_UP;
      end else if (beat.value == switch_down_code) begin
        sw_pos = sbfd_pkg::SW_DOWN;
      end
    end
  end

  always_comb begin
    res.frame_valid     = beat.frame_valid;
    res.connected       = beat.connected;
    res.last            = beat.last;
    res.channel_index   = '0;
    res.channel_value   = '0;
    res.center_offset   = '0;
    res.knob_offset     = '0;
    res.switch_position = sbfd_pkg::SW_NONE;
    if (beat.frame_valid) begin
      res.channel_index   = beat.index;
      res.channel_value   = beat.value;
      res.center_offset   = $signed({1'b0, beat.value} - {1'b0, stick_center});
      res.knob_offset     = $signed({1'b0, beat.value} - {1'b0, knob_base});
      res.switch_position = sw_pos;
    end
  end

  assign beat_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (beat_ready) begin
      out_valid_nxt = beat_valid;
      if (beat_valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/sbus_frame_decoder_unit.sv -----
// Data byte beats are taken while the block is idle; an idle-line beat keeps
// the block busy through 16 channel beats from one shared shifter on a good
// frame or one status beat on a bad one, plus any stall from the result side.
// The first result is registered in the sequencer state, then in the output register.
// Synchronous active-low reset clears the frame bytes, the link state and
// loads the default register values.
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit
// Serial-bus frame decoder: collects frame bytes and emits decoded channels.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sbfd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sbfd_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [sbfd_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [sbfd_pkg::CODE_W-1:0]     cfg_wdata
);

  logic [7:0]                 loss_limit_r;
  logic [7:0]                 loss_limit_nxt;
  logic [sbfd_pkg::CODE_W-1:0] stick_center_r;
  logic [sbfd_pkg::CODE_W-1:0] stick_center_nxt;
  logic [sbfd_pkg::CODE_W-1:0] knob_base_r;
  logic [sbfd_pkg::CODE_W-1:0] knob_base_nxt;
  logic [sbfd_pkg::CODE_W-1:0] sw_up_r;
  logic [sbfd_pkg::CODE_W-1:0] sw_up_nxt;
  logic [sbfd_pkg::CODE_W-1:0] sw_mid_r;
  logic [sbfd_pkg::CODE_W-1:0] sw_mid_nxt;
  logic [sbfd_pkg::CODE_W-1:0] sw_down_r;
  logic [sbfd_pkg::CODE_W-1:0] sw_down_nxt;

  logic              busy;
  logic              in_take;
  logic              byte_we;
  logic              frame_end;
  logic              beat_valid;
  logic              beat_ready;
  sbfd_pkg::frame_t  frame;
  sbfd_pkg::beat_t   beat;

  assign in_ready  = !busy;
  assign in_take   = in_valid && in_ready;
  assign byte_we   = in_take && (in_data.action == sbfd_pkg::ACT_BYTE);
  assign frame_end = in_take && (in_data.action == sbfd_pkg::ACT_IDLE);

  always_comb begin
    loss_limit_nxt   = loss_limit_r;
    stick_center_nxt = stick_center_r;
    knob_base_nxt    = knob_base_r;
    sw_up_nxt        = sw_up_r;
    sw_mid_nxt       = sw_mid_r;
    sw_down_nxt      = sw_down_r;
    if (cfg_we) begin
      case (cfg_index)
        sbfd_pkg::REG_LOSS_LIMIT:   loss_limit_nxt   = cfg_wdata[7:0];
        sbfd_pkg::REG_STICK_CENTER: stick_center_nxt = cfg_wdata;
        sbfd_pkg::REG_KNOB_BASE:    knob_base_nxt    = cfg_wdata;
        sbfd_pkg::REG_SWITCH_UP:    sw_up_nxt        = cfg_wdata;
        sbfd_pkg::REG_SWITCH_MID:   sw_mid_nxt       = cfg_wdata;
        sbfd_pkg::REG_SWITCH_DOWN:  sw_down_nxt      = cfg_wdata;
        default: begin
          loss_limit_nxt = loss_limit_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_limit_r   <= sbfd_pkg::RST_LOSS_LIMIT;
      stick_center_r <= sbfd_pkg::RST_STICK_CENTER;
      knob_base_r    <= sbfd_pkg::RST_KNOB_BASE;
      sw_up_r        <= sbfd_pkg::RST_SWITCH_UP;
      sw_mid_r       <= sbfd_pkg::RST_SWITCH_MID;
      sw_down_r      <= sbfd_pkg::RST_SWITCH_DOWN;
    end else begin
      loss_limit_r   <= loss_limit_nxt;
      stick_center_r <= stick_center_nxt;
      knob_base_r    <= knob_base_nxt;
      sw_up_r        <= sw_up_nxt;
      sw_mid_r       <= sw_mid_nxt;
      sw_down_r      <= sw_down_nxt;
    end
  end

  sbfd_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_we   (byte_we),
    .byte_in   (in_data.byte_value),
    .frame_end (frame_end),
    .frame     (frame)
  );

  sbfd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_end  (frame_end),
    .frame      (frame),
    .loss_limit (loss_limit_r),
    .beat_ready (beat_ready),
    .busy       (busy),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sbfd_post u_post (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat_valid       (beat_valid),
    .beat             (beat),
    .stick_center     (stick_center_r),
    .knob_base        (knob_base_r),
    .switch_up_code   (sw_up_r),
    .switch_mid_code  (sw_mid_r),
    .switch_down_code (sw_down_r),
    .out_ready        (out_ready),
    .beat_ready       (beat_ready),
    .out_valid        (out_valid),
    .out_data         (out_data)
  );

endmodule

// ----- src/sbfd_checker.sv -----
// ----------------------------------------------------------------------------
// sbfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbfd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input sbfd_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_ready,
  input sbfd_pkg::out_t  out_data
);

  `SBFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `SBFD_ASSERT_NEXT(a_busy_after_idle, in_valid && in_ready && in_data.action == sbfd_pkg::ACT_IDLE, !in_ready, "input taken right after an idle-line beat")
  `SBFD_ASSERT_IMPL(a_status_beat, out_valid && !out_data.frame_valid, out_data.last && out_data.channel_index == '0 && out_data.switch_position == sbfd_pkg::SW_NONE, "malformed status beat")
  `SBFD_ASSERT_IMPL(a_last_channel, out_valid && out_data.frame_valid, out_data.last == (out_data.channel_index == sbfd_pkg::CH_LAST), "last flag out of step with channel index")
  `SBFD_ASSERT_IMPL(a_link_up, out_valid && out_data.frame_valid, out_data.connected, "good frame without link up")

endmodule

bind sbus_frame_decoder_unit sbfd_checker u_sbfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
